>>> rtl/core/modular_exponentiation_defines.svh
// Assertion macros used by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MODEXP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/modexp_pkg.sv
// Shared constants and types of the modular exponentiation block.
`default_nettype none
package modexp_pkg;
	localparam int DATA_W = 32;
	localparam int OPND_W = 32;
	localparam int CNT_W = $clog2(OPND_W);
	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_EXPONENT = 1'b1;

	localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(2);
	localparam logic [DATA_W-1:0] EXPONENT_RESET = '0;

	typedef logic [OPND_W-1:0] opnd_t;

	typedef struct packed {
		logic [DATA_W-1:0] modulus;
		logic [DATA_W-1:0] exponent;
	} cfg_t;

	typedef struct packed {
		logic  start;
		opnd_t a;
		opnd_t b;
		opnd_t m;
	} mm_ctl_t;

	typedef struct packed {
		logic  done;
		opnd_t product;
	} mm_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/modular_exponentiation.sv
// Every modular multiply runs on the shared bit-serial unit.
// An item needs one reduction, one multiply per set exponent bit and one square per bit
// below the top set bit; with a modulus below 2 the result is 0 and no multiply is run.
// Throughput: one item at a time; message_ready is high only while the sequencer is idle.
// Reset: arst_n clears the sequencer and output valid and loads modulus 2, exponent 0.
`default_nettype none
module modular_exponentiation
	import modexp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [DATA_W-1:0]  message,
	input  wire logic               message_valid,
	output logic                    message_ready,
	output logic      [DATA_W-1:0]  result,
	output logic                    result_valid,
	input  wire logic               result_ready,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_CHECK,
		S_MUL,
		S_SQR,
		S_FINISH
	} state_t;

	state_t  state_q;
	cfg_t    cfg;
	mm_ctl_t mm_ctl_q;
	mm_sts_t mm_sts;
	opnd_t   acc_q;
	opnd_t   base_q;
	opnd_t   exp_q;
	opnd_t   result_q;
	logic    result_valid_q;
	opnd_t   cfg_m;
	opnd_t   cfg_e;

	modexp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	modexp_modmul u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mm_ctl_q),
		.sts   (mm_sts)
	);

	assign cfg_m = cfg.modulus[OPND_W-1:0];
	assign cfg_e = cfg.exponent[OPND_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mm_ctl_q <= '0;
			result_valid_q <= 1'b0;
			acc_q <= '0;
			base_q <= '0;
			exp_q <= '0;
			result_q <= '0;
		end else begin
			mm_ctl_q.start <= 1'b0;
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (message_valid) begin
						if (cfg_m < OPND_W'(2)) begin
							acc_q <= '0;
							state_q <= S_FINISH;
						end else begin
							acc_q <= OPND_W'(1);
							exp_q <= cfg_e;
							mm_ctl_q.start <= 1'b1;
							mm_ctl_q.a <= OPND_W'(1);
							mm_ctl_q.b <= message[OPND_W-1:0];
							mm_ctl_q.m <= cfg_m;
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (mm_sts.done) begin
						base_q <= mm_sts.product;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (exp_q == '0) begin
						state_q <= S_FINISH;
					end else if (exp_q[0]) begin
						mm_ctl_q.start <= 1'b1;
						mm_ctl_q.a <= acc_q;
						mm_ctl_q.b <= base_q;
						state_q <= S_MUL;
					end else begin
						mm_ctl_q.start <= 1'b1;
						mm_ctl_q.a <= base_q;
						mm_ctl_q.b <= base_q;
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (mm_sts.done) begin
						acc_q <= mm_sts.product;
						if (exp_q[OPND_W-1:1] == '0) begin
							exp_q <= '0;
							state_q <= S_FINISH;
						end else begin
							mm_ctl_q.start <= 1'b1;
							mm_ctl_q.a <= base_q;
							mm_ctl_q.b <= base_q;
							state_q <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (mm_sts.done) begin
						base_q <= mm_sts.product;
						exp_q <= {1'b0, exp_q[OPND_W-1:1]};
						state_q <= S_CHECK;
					end
				end
				S_FINISH: begin
					if (!result_valid_q || result_ready) begin
						result_q <= acc_q;
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign message_ready = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result = DATA_W'(result_q);
endmodule
`default_nettype wire

>>> rtl/core/modexp_regs.sv
// APB configuration registers holding the modulus and the exponent.
`default_nettype none
module modexp_regs
	import modexp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	output cfg_t                    cfg
);
	logic [DATA_W-1:0]    modulus_q;
	logic [DATA_W-1:0]    exponent_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx = paddr[PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			exponent_q <= EXPONENT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MODULUS: modulus_q <= pwdata;
				REG_EXPONENT: exponent_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODULUS: prdata = modulus_q;
			REG_EXPONENT: prdata = exponent_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.modulus = modulus_q;
	assign cfg.exponent = exponent_q;
endmodule
`default_nettype wire

>>> rtl/core/modexp_modmul.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`default_nettype none
module modexp_modmul
	import modexp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mm_ctl_t ctl,
	output mm_sts_t      sts
);
	opnd_t             a_q;
	opnd_t             b_q;
	opnd_t             m_q;
	opnd_t             r_q;
	opnd_t             r_next;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [OPND_W+1:0] t;
	logic [OPND_W+1:0] t1;
	logic [OPND_W+1:0] t2;
	logic [OPND_W+1:0] m1;
	logic [OPND_W+1:0] m2;

	always_comb begin
		m1 = {2'b00, m_q};
		m2 = {1'b0, m_q, 1'b0};
		t = {1'b0, r_q, 1'b0} + (b_q[OPND_W-1] ? {2'b00, a_q} : '0);
		t1 = t - m1;
		t2 = t - m2;
		if (t >= m2) begin
			r_next = t2[OPND_W-1:0];
		end else if (t >= m1) begin
			r_next = t1[OPND_W-1:0];
		end else begin
			r_next = t[OPND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(OPND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= ctl.a;
			b_q <= ctl.b;
			m_q <= ctl.m;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[OPND_W-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign sts.done = done_q;
	assign sts.product = r_q;
endmodule
`default_nettype wire

>>> rtl/core/modexp_checker.sv
// Port-level checker for the modular exponentiation block, bound to the top level.
`default_nettype none
`include "modular_exponentiation_defines.svh"
module modexp_checker
	import modexp_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              message_valid,
	input wire logic              message_ready,
	input wire logic [DATA_W-1:0] result,
	input wire logic              result_valid,
	input wire logic              result_ready
);
	`MODEXP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "Stalled result changed or dropped.")
	`MODEXP_ASSERT_NEXT(a_busy_after_request, clk, arst_n, message_valid && message_ready, !message_ready, "Block still ready right after accepting a request.")
	`MODEXP_ASSERT_SAME(a_ready_with_result, clk, arst_n, $rose(message_ready), result_valid, "Block became ready without presenting a result.")
endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
`default_nettype wire
